// File: hdl/rgb2i_pkg.sv
// Shared types and constants for the RGB to 4:2:0 converter.
// No dependencies; imported by the raster, line store, colour and top modules.
package rgb2i_pkg;

	localparam int MAX_HALF_WIDTH_DEF = 1024;
	localparam int HW_W = 11;
	localparam logic [HW_W-1:0] HALF_WIDTH_RESET = 11'd320;

	// Register index decoded from paddr[2].
	localparam logic REG_HALF_WIDTH = 1'b0;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [9:0] red;
		logic [9:0] green;
		logic [9:0] blue;
	} sums_t;

	typedef struct packed {
		logic we;
		logic re;
	} store_cmd_t;

	typedef struct packed {
		logic odd_row;
		logic odd_column;
	} raster_stat_t;

endpackage

// File: hdl/rgb2i_line_store.sv
// Line store holding the pair sums of the previous even row.
// Depends on rgb2i_pkg for the sums and command types.
module rgb2i_line_store import rgb2i_pkg::*; #(
	parameter int MAX_HALF_WIDTH = MAX_HALF_WIDTH_DEF
) (
	input  logic       clk,
	input  store_cmd_t cmd,
	input  logic [((MAX_HALF_WIDTH > 1) ? $clog2(MAX_HALF_WIDTH) : 1)-1:0] addr,
	input  sums_t      wdata,
	output sums_t      rdata
);

	sums_t mem [MAX_HALF_WIDTH];

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[addr] <= wdata;
		end
		if (cmd.re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// File: hdl/rgb2i_raster.sv
// Raster position tracking, pair summing and the input pipeline register.
// Depends on rgb2i_pkg; drives the line store commands.
module rgb2i_raster import rgb2i_pkg::*; #(
	parameter int MAX_HALF_WIDTH = MAX_HALF_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  pixel_t           pixel,
	input  logic             frame_start,
	input  logic [HW_W-1:0]  half_width,
	output store_cmd_t       cmd,
	output logic [((MAX_HALF_WIDTH > 1) ? $clog2(MAX_HALF_WIDTH) : 1)-1:0] addr,
	output sums_t            pair_sum,
	output raster_stat_t     stat,
	output pixel_t           pixel_s1,
	output sums_t            pair_sum_s1,
	output logic             chroma_s1
);

	localparam int AW    = (MAX_HALF_WIDTH > 1) ? $clog2(MAX_HALF_WIDTH) : 1;
	localparam int CW    = $clog2(2 * MAX_HALF_WIDTH);
	localparam int CMP_W = (CW + 1 > HW_W + 1) ? CW + 1 : HW_W + 1;
	localparam logic [CMP_W-1:0] MAX_HW = CMP_W'(MAX_HALF_WIDTH);

	logic [CW-1:0]    col_q;
	logic             odd_q;
	pixel_t           left_q;
	logic [CW-1:0]    col_eff;
	logic             odd_eff;
	logic [CMP_W-1:0] hw_ext;
	logic [CMP_W-1:0] hw_eff;
	logic [CMP_W-1:0] line_w;
	logic [CMP_W-1:0] col_next;

	// A frame start forces the pixel to row 0, column 0 before it is used.
	assign col_eff = frame_start ? '0 : col_q;
	assign odd_eff = frame_start ? 1'b0 : odd_q;

	assign hw_ext = CMP_W'(half_width);
	always_comb begin
		if (hw_ext == '0) begin
			hw_eff = CMP_W'(1);
		end else if (hw_ext > MAX_HW) begin
			hw_eff = MAX_HW;
		end else begin
			hw_eff = hw_ext;
		end
	end
	assign line_w   = hw_eff << 1;
	assign col_next = CMP_W'(col_eff) + CMP_W'(1);

	assign pair_sum.red   = 10'(pixel.red) + 10'(left_q.red);
	assign pair_sum.green = 10'(pixel.green) + 10'(left_q.green);
	assign pair_sum.blue  = 10'(pixel.blue) + 10'(left_q.blue);

	assign cmd.we = accept && col_eff[0] && !odd_eff;
	assign cmd.re = accept && col_eff[0] && odd_eff;
	assign addr   = AW'(col_eff >> 1);

	assign stat.odd_row    = odd_q;
	assign stat.odd_column = col_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			odd_q  <= 1'b0;
			left_q <= '0;
		end else if (accept) begin
			if (!col_eff[0]) begin
				left_q <= pixel;
			end
			if (col_next >= line_w) begin
				col_q <= '0;
				odd_q <= !odd_eff;
			end else begin
				col_q <= CW'(col_next);
				odd_q <= odd_eff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1    <= pixel;
			pair_sum_s1 <= pair_sum;
			chroma_s1   <= col_eff[0] && odd_eff;
		end
	end

endmodule

// File: hdl/rgb2i_colour.sv
// Luma and 2x2 averaged chroma arithmetic feeding the output register.
// Depends on rgb2i_pkg for the pixel and sums types.
module rgb2i_colour import rgb2i_pkg::*; (
	input  logic       clk,
	input  logic       load,
	input  pixel_t     pixel_s1,
	input  sums_t      pair_sum_s1,
	input  sums_t      stored,
	input  logic       chroma_s1,
	output logic [7:0] luma_s2,
	output logic [7:0] cb_s2,
	output logic [7:0] cr_s2,
	output logic       chroma_valid_s2
);

	localparam int Y_R = 66;
	localparam int Y_G = 129;
	localparam int Y_B = 25;
	localparam int CB_R = 38;
	localparam int CB_G = 74;
	localparam int CB_B = 112;
	localparam int CR_R = 112;
	localparam int CR_G = 94;
	localparam int CR_B = 18;
	localparam int ROUND = 128;
	localparam int Y_OFFSET = 16;
	// Rounding plus the chroma offset of 128 scaled by 256.
	localparam int C_BIAS = 128 + 32768;

	logic [16:0] y_acc;
	logic [7:0]  luma;
	logic [10:0] tot_r, tot_g, tot_b;
	logic [7:0]  av_r, av_g, av_b;
	logic [16:0] cb_acc, cr_acc;

	assign y_acc = 17'(Y_R) * 17'(pixel_s1.red) + 17'(Y_G) * 17'(pixel_s1.green)
		+ 17'(Y_B) * 17'(pixel_s1.blue) + 17'(ROUND);
	assign luma  = y_acc[15:8] + 8'(Y_OFFSET);

	assign tot_r = 11'(pair_sum_s1.red) + 11'(stored.red);
	assign tot_g = 11'(pair_sum_s1.green) + 11'(stored.green);
	assign tot_b = 11'(pair_sum_s1.blue) + 11'(stored.blue);
	assign av_r  = 8'(tot_r >> 2);
	assign av_g  = 8'(tot_g >> 2);
	assign av_b  = 8'(tot_b >> 2);

	// The biased totals never go negative, so the upper byte is a plain floor.
	assign cb_acc = 17'(CB_B) * 17'(av_b) + 17'(C_BIAS)
		- 17'(CB_R) * 17'(av_r) - 17'(CB_G) * 17'(av_g);
	assign cr_acc = 17'(CR_R) * 17'(av_r) + 17'(C_BIAS)
		- 17'(CR_G) * 17'(av_g) - 17'(CR_B) * 17'(av_b);

	always_ff @(posedge clk) begin
		if (load) begin
			luma_s2         <= luma;
			chroma_valid_s2 <= chroma_s1;
			cb_s2           <= chroma_s1 ? cb_acc[15:8] : 8'd0;
			cr_s2           <= chroma_s1 ? cr_acc[15:8] : 8'd0;
		end
	end

endmodule

// File: hdl/rgb32_to_i420_box_averaged.sv
// Top level of the RGB to 4:2:0 YCbCr converter with 2x2 chroma averaging.
// Depends on rgb2i_pkg, rgb2i_raster, rgb2i_line_store and rgb2i_colour.

// Converts a raster stream of pixels to BT.601 studio-range luma for every pixel
// and, on each odd column of an odd row, Cb and Cr averaged over the 2x2 block,
// flagged in m_tuser. One pixel is taken per clock when the output is not held
// back. Each pixel passes through an input register (with the registered
// line-store read) and then an output register before its result is presented.
// The line store keeps the pair sums of the last even row and is never cleared:
// every odd row must be preceded by an even row of the same width in the frame.
// The line width is twice half_width, written at byte address 0 of the APB port.
module rgb32_to_i420_box_averaged import rgb2i_pkg::*; #(
	parameter int MAX_HALF_WIDTH = MAX_HALF_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // blue [7:0], green [15:8], red [23:16]
	input  logic [0:0]  s_tuser,  // frame_start [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // luma [7:0], cb [15:8], cr [23:16]
	output logic [0:0]  m_tuser,  // chroma_valid [0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = (MAX_HALF_WIDTH > 1) ? $clog2(MAX_HALF_WIDTH) : 1;

	logic [HW_W-1:0] half_width_q;
	logic            v_s1, v_s2;
	logic            s_acc, adv_out;
	pixel_t          pixel;
	store_cmd_t      cmd;
	logic [AW-1:0]   addr;
	sums_t           pair_sum, pair_sum_s1, stored;
	raster_stat_t    stat;
	pixel_t          pixel_s1;
	logic            chroma_s1;
	logic [7:0]      luma_s2, cb_s2, cr_s2;
	logic            chroma_valid_s2;

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_HALF_WIDTH) ? 32'(half_width_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q <= HALF_WIDTH_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_HALF_WIDTH) begin
			half_width_q <= pwdata[HW_W-1:0];
		end
	end

	// Two-stage flow control: the input stage refills while the output waits.
	assign adv_out  = v_s1 && (!v_s2 || m_tready);
	assign s_tready = !v_s1 || adv_out;
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s_acc) begin
				v_s1 <= 1'b1;
			end else if (adv_out) begin
				v_s1 <= 1'b0;
			end
			if (adv_out) begin
				v_s2 <= 1'b1;
			end else if (m_tready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	assign pixel.blue  = s_tdata[7:0];
	assign pixel.green = s_tdata[15:8];
	assign pixel.red   = s_tdata[23:16];

	rgb2i_raster #(
		.MAX_HALF_WIDTH(MAX_HALF_WIDTH)
	) u_raster (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (s_acc),
		.pixel      (pixel),
		.frame_start(s_tuser[0]),
		.half_width (half_width_q),
		.cmd        (cmd),
		.addr       (addr),
		.pair_sum   (pair_sum),
		.stat       (stat),
		.pixel_s1   (pixel_s1),
		.pair_sum_s1(pair_sum_s1),
		.chroma_s1  (chroma_s1)
	);

	rgb2i_line_store #(
		.MAX_HALF_WIDTH(MAX_HALF_WIDTH)
	) u_line_store (
		.clk  (clk),
		.cmd  (cmd),
		.addr (addr),
		.wdata(pair_sum),
		.rdata(stored)
	);

	rgb2i_colour u_colour (
		.clk            (clk),
		.load           (adv_out),
		.pixel_s1       (pixel_s1),
		.pair_sum_s1    (pair_sum_s1),
		.stored         (stored),
		.chroma_s1      (chroma_s1),
		.luma_s2        (luma_s2),
		.cb_s2          (cb_s2),
		.cr_s2          (cr_s2),
		.chroma_valid_s2(chroma_valid_s2)
	);

	assign m_tdata = {cr_s2, cb_s2, luma_s2};
	assign m_tuser = chroma_valid_s2;

	// An empty output register always lets a transfer into the input stage.
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s2 |-> s_tready)
		else $error("input stalled while the output register is empty");

	// The line store is never written and read for the same pixel.
	a_store_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.we && cmd.re))
		else $error("line store written and read together");

	// A frame start pixel lands on the even row and leaves an odd column next.
	a_frame_start_row: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && s_tuser[0] |=> !stat.odd_row && stat.odd_column)
		else $error("frame start did not restart the raster position");

	// Chroma only leaves with a pixel that entered on an odd row, odd column.
	a_chroma_position: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && !(stat.odd_row && stat.odd_column) && !s_tuser[0] |=> !chroma_s1)
		else $error("chroma flagged outside a 2x2 block end");

endmodule

// File: tb/rgb32_to_i420_box_averaged_tb.sv
// Self-checking testbench for the RGB to 4:2:0 converter with 2x2 chroma averaging.
// Streams pixels through the block, predicts luma and chroma on every accepted
// transfer and compares each output transfer. Depends on rgb2i_pkg and the top level.
`timescale 1ns / 1ps

module rgb32_to_i420_box_averaged_tb;
	import rgb2i_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam logic [2:0] HALF_WIDTH_ADDR = {REG_HALF_WIDTH, 2'b00};

	typedef struct packed {
		logic   frame_start;
		pixel_t px;
	} pixel_item_t;

	typedef struct packed {
		logic       chroma_valid;
		logic [7:0] cr;
		logic [7:0] cb;
		logic [7:0] luma;
	} ycc_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;  // blue [7:0], green [15:8], red [23:16]
	logic [0:0]  s_tuser = '0;  // frame_start [0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;       // luma [7:0], cb [15:8], cr [23:16]
	logic [0:0]  m_tuser;       // chroma_valid [0]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	rgb32_to_i420_box_averaged dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	pixel_item_t pixel_queue[$];
	ycc_t        expected_ycc[$];
	pixel_item_t next_item;
	ycc_t        oldest_ycc;
	int          errors = 0;
	int          src_idle_pct = 0;
	int          snk_idle_pct = 0;
	int          src_gap = 0;
	int          snk_gap = 0;
	int          quiet_cycles = 0;

	// Predictor state and its copy of the register.
	logic [10:0] cfg_half_width = HALF_WIDTH_RESET;
	logic        pred_odd_row = 1'b0;
	int          pred_column = 0;
	pixel_t      pred_left = '0;
	sums_t       pred_sums[MAX_HALF_WIDTH_DEF];

	// Position of the stream as generated, used to keep line-store reads legal.
	logic        gen_odd_row = 1'b0;
	int          gen_column = 0;
	logic        gen_written[MAX_HALF_WIDTH_DEF];

	initial begin
		foreach (gen_written[i]) gen_written[i] = 1'b0;
	end

	function automatic int line_width(input logic [10:0] hw);
		if (hw == 0)
			return 2;
		if (hw > MAX_HALF_WIDTH_DEF)
			return 2 * MAX_HALF_WIDTH_DEF;
		return 2 * int'(hw);
	endfunction

	function automatic logic [7:0] chroma(input int c0, input int c1, input int c2,
			input int r, input int g, input int b);
		int t;
		// The offset of 128 << 8 keeps the sum positive, so the shift is a floor.
		t = c0 * r + c1 * g + c2 * b + 128 + 32768;
		return 8'(t >> 8);
	endfunction

	function automatic pixel_t rand_pixel();
		pixel_t p;
		p = pixel_t'(24'($urandom()));
		if ($urandom_range(0, 7) == 0)
			p.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		if ($urandom_range(0, 7) == 0)
			p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		if ($urandom_range(0, 7) == 0)
			p.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return p;
	endfunction

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			errors++;
		end
	endtask

	task automatic convert_pixel(input pixel_t px, input logic fs);
		ycc_t  res;
		sums_t stored;
		int    w, y, sr, sg, sb;
		res = '0;
		w = line_width(cfg_half_width);
		if (fs) begin
			pred_odd_row = 1'b0;
			pred_column = 0;
		end
		y = ((66 * int'(px.red) + 129 * int'(px.green) + 25 * int'(px.blue) + 128) >> 8) + 16;
		res.luma = 8'(y);
		if (pred_column[0]) begin
			sr = int'(px.red) + int'(pred_left.red);
			sg = int'(px.green) + int'(pred_left.green);
			sb = int'(px.blue) + int'(pred_left.blue);
			if (!pred_odd_row) begin
				pred_sums[pred_column >> 1] = {sr[9:0], sg[9:0], sb[9:0]};
			end else begin
				stored = pred_sums[pred_column >> 1];
				sr = (sr + int'(stored.red)) >> 2;
				sg = (sg + int'(stored.green)) >> 2;
				sb = (sb + int'(stored.blue)) >> 2;
				res.cb = chroma(-38, -74, 112, sr, sg, sb);
				res.cr = chroma(112, -94, -18, sr, sg, sb);
				res.chroma_valid = 1'b1;
			end
		end else begin
			pred_left = px;
		end
		if (pred_column + 1 >= w) begin
			pred_column = 0;
			pred_odd_row = !pred_odd_row;
		end else begin
			pred_column++;
		end
		expected_ycc.push_back(res);
	endtask

	// A frame start is forced where the next pixel would read a line-store entry
	// that no even row has written yet.
	task automatic queue_pixel(input pixel_t px, input logic fs);
		logic f;
		int   w;
		f = fs;
		w = line_width(cfg_half_width);
		if (!f && gen_odd_row && gen_column[0] && !gen_written[gen_column >> 1])
			f = 1'b1;
		if (f) begin
			gen_column = 0;
			gen_odd_row = 1'b0;
		end
		if (gen_column[0] && !gen_odd_row)
			gen_written[gen_column >> 1] = 1'b1;
		if (gen_column + 1 >= w) begin
			gen_column = 0;
			gen_odd_row = !gen_odd_row;
		end else begin
			gen_column++;
		end
		pixel_queue.push_back({f, px});
	endtask

	task automatic apb_access(input logic wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= HALF_WIDTH_ADDR;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(negedge clk);
		while (!pready);
		rdata = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_half_width(input logic [10:0] value);
		logic [31:0] word, rd;
		// Bits above the register are filled at random; they must be ignored.
		word = $urandom();
		word[10:0] = value;
		apb_access(1'b1, word, rd);
		cfg_half_width = value;
		apb_access(1'b0, '0, rd);
		check_field("half_width readback", value, rd[10:0]);
	endtask

	task automatic wait_idle();
		while (pixel_queue.size() != 0 || s_tvalid || expected_ycc.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic random_phase(input logic [10:0] hw, input int n_items, input logic calm);
		int made, rows, len, w;
		write_half_width(hw);
		src_idle_pct = calm ? 0 : 20 * $urandom_range(0, 2);
		snk_idle_pct = calm ? 0 : 20 * $urandom_range(0, 2);
		w = line_width(cfg_half_width);
		made = 0;
		while (made < n_items) begin
			case ($urandom_range(0, 9))
				7: begin
					// Frame of odd height: the next frame start cuts it short.
					rows = 2 * $urandom_range(0, 1) + 1;
					for (int r = 0; r < rows; r++)
						for (int c = 0; c < w; c++) begin
							queue_pixel(rand_pixel(), r == 0 && c == 0);
							made++;
						end
				end
				8, 9: begin
					len = $urandom_range(1, 8);
					for (int i = 0; i < len; i++) begin
						queue_pixel(rand_pixel(), $urandom_range(0, 7) == 0);
						made++;
					end
				end
				default: begin
					rows = 2 * $urandom_range(1, 2);
					for (int r = 0; r < rows; r++)
						for (int c = 0; c < w; c++) begin
							queue_pixel(rand_pixel(), r == 0 && c == 0);
							made++;
						end
				end
			endcase
		end
		wait_idle();
	endtask

	// Source side: one pending pixel per transfer, with random bursts of idle cycles.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (src_gap != 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (pixel_queue.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if ($urandom_range(0, 99) < src_idle_pct) begin
				src_gap = $urandom_range(0, 5);
				s_tvalid <= 1'b0;
			end else begin
				next_item = pixel_queue.pop_front();
				s_tdata <= next_item.px;
				s_tuser <= next_item.frame_start;
				s_tvalid <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			convert_pixel(pixel_t'(s_tdata), s_tuser[0]);
	end

	// Sink side: compares each output transfer and stalls in random bursts.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_ycc.size() == 0) begin
				$display("%0t ns: output transfer with nothing expected, tdata %h tuser %b",
					$time, m_tdata, m_tuser);
				errors++;
			end else begin
				oldest_ycc = expected_ycc.pop_front();
				check_field("luma", oldest_ycc.luma, m_tdata[7:0]);
				check_field("cb", oldest_ycc.cb, m_tdata[15:8]);
				check_field("cr", oldest_ycc.cr, m_tdata[23:16]);
				check_field("chroma_valid", oldest_ycc.chroma_valid, m_tuser[0]);
			end
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (snk_gap != 0) begin
			snk_gap--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 99) < snk_idle_pct) begin
			snk_gap = $urandom_range(0, 5);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t ns: watchdog, no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	logic [31:0] reset_rd;
	logic [10:0] phase_widths[10] = '{11'd2, 11'd1, 11'd4, 11'd3, 11'd6,
		11'd2, 11'd5, 11'd1, 11'd8, 11'd3};

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		apb_access(1'b0, '0, reset_rd);
		check_field("half_width after reset", HALF_WIDTH_RESET, reset_rd[10:0]);

		// Directed: colour extremes on the narrowest line, then a frame start
		// in the middle of an odd row, then a half width of zero.
		src_idle_pct = 20;
		snk_idle_pct = 20;
		write_half_width(11'd1);
		queue_pixel(pixel_t'(24'h000000), 1'b1);
		repeat (3) queue_pixel(pixel_t'(24'h000000), 1'b0);
		queue_pixel(pixel_t'(24'hFFFFFF), 1'b1);
		repeat (3) queue_pixel(pixel_t'(24'hFFFFFF), 1'b0);
		queue_pixel(pixel_t'(24'hFF0000), 1'b1);
		queue_pixel(pixel_t'(24'h00FF00), 1'b0);
		queue_pixel(pixel_t'(24'h0000FF), 1'b0);
		queue_pixel(pixel_t'(24'hFFFFFF), 1'b0);
		queue_pixel(pixel_t'(24'h123456), 1'b1);
		queue_pixel(pixel_t'(24'h654321), 1'b0);
		queue_pixel(pixel_t'(24'hABCDEF), 1'b0);
		queue_pixel(pixel_t'(24'h00FFFF), 1'b1);
		queue_pixel(pixel_t'(24'hFF00FF), 1'b0);
		queue_pixel(pixel_t'(24'hFFFF00), 1'b0);
		queue_pixel(pixel_t'(24'h0000FF), 1'b0);
		wait_idle();
		write_half_width(11'd0);
		queue_pixel(rand_pixel(), 1'b1);
		repeat (3) queue_pixel(rand_pixel(), 1'b0);
		wait_idle();

		// Widest line: an all-ones register saturates, then the maximum proper,
		// each for part of a row.
		write_half_width(11'h7FF);
		queue_pixel(rand_pixel(), 1'b1);
		repeat (60) queue_pixel(rand_pixel(), 1'b0);
		wait_idle();
		write_half_width(11'(MAX_HALF_WIDTH_DEF));
		repeat (30) queue_pixel(rand_pixel(), 1'b0);
		wait_idle();

		// The first random phase narrows the line while the stream is mid-row.
		foreach (phase_widths[i])
			random_phase(phase_widths[i], 75, 1'b0);
		random_phase(11'd7, 75, 1'b1);

		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: filelist.f
hdl/rgb2i_pkg.sv
hdl/rgb2i_line_store.sv
hdl/rgb2i_raster.sv
hdl/rgb2i_colour.sv
hdl/rgb32_to_i420_box_averaged.sv
tb/rgb32_to_i420_box_averaged_tb.sv
